// ===== hw/rtl/ahdlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_pkg: shared types and constants of the async HDLC deframer
// Byte codes, status codes, FCS-16 constants and the queue word type.
// ----------------------------------------------------------------------------
package ahdlc_pkg;

    localparam int          MAX_FRAME_BYTES_DEF = 4096;
    localparam int          CFG_W               = 13;
    localparam logic [12:0] CAP_RESET           = 13'd4096;
    localparam int          QUEUE_DEPTH         = 2;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;

    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD = 16'hF0B8;
    localparam logic [15:0] FCS_POLY = 16'h8408;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_FCS_ERR  = 3'd2,
        ST_DISCARD  = 3'd3,
        ST_BUF_FULL = 3'd4
    } t_status;

    // One classified byte as it travels from front to back.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_flag;
        logic       is_esc;
        logic       esc_ok;   // 0x5E or 0x5D, legal after an escape
    } t_item;

    // Reflected CRC-16 (x^16+x^12+x^5+1), one byte, bit at a time.
    function automatic logic [15:0] fcs16_update(input logic [15:0] fcs,
                                                 input logic [7:0]  b);
        logic [15:0] f;
        f = fcs ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

endpackage

// ===== hw/rtl/async_hdlc_deframer_fcs16_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_hdlc_deframer_fcs16_top: async HDLC byte deframer with FCS-16 check
// Destuffs a received byte stream, tracks frame boundaries and checks the
// running FCS-16 at each closing flag.
// ----------------------------------------------------------------------------
// One raw byte enters per accepted input word and exactly one result word
// comes out for it, in order. Throughput is one byte per clock while the
// output is not stalled: the back end applies hunt/escape/length/FCS-16 state
// for a whole byte at once, so bytes stream back to back. An accepted byte is
// first written into the queue, then the back end updates the output register
// from it. A two-word queue between the classifier and the back end
// absorbs output stalls so the input keeps flowing while a result waits.
// Status: 0 no frame end, 1 good frame (payload_len = stored bytes minus the
// two FCS bytes), 2 FCS error, 3 discard (bad escape), 4 buffer full. Each
// stored destuffed byte is reported with data_valid, its value and its index
// in the frame. The capacity register may be written at any time the block
// is idle; values above MAX_FRAME_BYTES act as MAX_FRAME_BYTES.
// ----------------------------------------------------------------------------
module async_hdlc_deframer_fcs16_top
    import ahdlc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: capacity register
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input byte channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [11:0]       o_payload_len,
    output logic              o_data_valid,
    output logic [7:0]        o_data_byte,
    output logic [11:0]       o_data_index
);

    logic  push, q_full, q_valid, pop;
    t_item push_item, head_item;

    // Capacity writes are taken whenever out of reset; software only writes
    // while idle.
    assign o_cfg_ready = i_rst_n;

    // Front: accept and classify raw bytes.
    ahdlc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (push_item)
    );

    // Decoupling queue.
    ahdlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (pop)
    );

    // Back: frame state, FCS and result register.
    ahdlc_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_item      (head_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_payload_len (o_payload_len),
        .o_data_valid  (o_data_valid),
        .o_data_byte   (o_data_byte),
        .o_data_index  (o_data_index)
    );

endmodule

// ===== hw/rtl/ahdlc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_front: input acceptance and byte classification
// Tags each received byte as flag, escape or legal escaped code and pushes it
// into the queue; stalls the sender while the queue is full or reset has not yet been seen released.
// ----------------------------------------------------------------------------
module ahdlc_front
    import ahdlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    logic r_rst_seen;  // holds off input until a clock edge has seen reset released

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_seen <= 1'b0;
        end else begin
            r_rst_seen <= 1'b1;
        end
    end

    assign o_in_stall = i_q_full || !r_rst_seen;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_item.byte_val = i_in_byte;
        o_item.is_flag  = (i_in_byte == FLAG_BYTE);
        o_item.is_esc   = (i_in_byte == ESC_BYTE);
        o_item.esc_ok   = (i_in_byte == (FLAG_BYTE ^ ESC_XOR)) ||
                          (i_in_byte == (ESC_BYTE ^ ESC_XOR));
    end

endmodule

// ===== hw/rtl/ahdlc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_queue: short FIFO between front and back
// Holds classified bytes so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ahdlc_queue
    import ahdlc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/ahdlc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_back: deframing state and result register
// Applies each classified byte to hunt/escape/length/FCS state and registers
// one result word per byte.
// ----------------------------------------------------------------------------
module ahdlc_back
    import ahdlc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [11:0]       o_payload_len,
    output logic              o_data_valid,
    output logic [7:0]        o_data_byte,
    output logic [11:0]       o_data_index
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;

    logic [CFG_W-1:0] r_cap;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_hunt, n_hunt;
    logic             r_esc, n_esc;
    logic [15:0]      r_fcs, n_fcs;

    logic             r_out_valid;
    t_status          r_status, n_status;
    logic [11:0]      r_info, n_info;
    logic             r_dvalid, n_dvalid;
    logic [7:0]       r_dbyte, n_dbyte;
    logic [11:0]      r_dindex, n_dindex;

    logic [CMP_W-1:0] cap_ext, max_ext, cap_eff, len_ext, info_ext;
    logic [7:0]       store_byte;
    logic             do_store;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        cap_ext  = CMP_W'(r_cap);
        max_ext  = CMP_W'(MAX_FRAME_BYTES);
        cap_eff  = (cap_ext > max_ext) ? max_ext : cap_ext;
        len_ext  = CMP_W'(r_len);
        info_ext = len_ext - CMP_W'(2);
    end

    always_comb begin
        n_len      = r_len;
        n_hunt     = r_hunt;
        n_esc      = r_esc;
        n_fcs      = r_fcs;
        n_status   = ST_NONE;
        n_info     = '0;
        do_store   = 1'b0;
        store_byte = i_q_item.byte_val;

        priority if (r_hunt && !i_q_item.is_flag) begin
            n_len = '0;
            n_fcs = FCS_INIT;
        end else if (i_q_item.is_flag) begin
            n_hunt = 1'b0;
            if (len_ext > CMP_W'(2)) begin
                if (r_fcs != FCS_GOOD) begin
                    n_status = ST_FCS_ERR;
                end else begin
                    n_status = ST_GOOD;
                    n_info   = info_ext[11:0];
                end
            end
            n_len = '0;
            n_fcs = FCS_INIT;
        end else if (i_q_item.is_esc) begin
            if (!r_esc) begin
                n_esc = 1'b1;
            end else begin
                n_esc    = 1'b0;
                n_hunt   = 1'b1;
                n_len    = '0;
                n_fcs    = FCS_INIT;
                n_status = ST_DISCARD;
            end
        end else if (len_ext >= cap_eff) begin
            n_hunt   = 1'b1;
            n_len    = '0;
            n_fcs    = FCS_INIT;
            n_status = ST_BUF_FULL;
        end else if (r_esc) begin
            n_esc = 1'b0;
            if (i_q_item.esc_ok) begin
                do_store   = 1'b1;
                store_byte = i_q_item.byte_val ^ ESC_XOR;
            end else begin
                n_hunt   = 1'b1;
                n_len    = '0;
                n_fcs    = FCS_INIT;
                n_status = ST_DISCARD;
            end
        end else begin
            do_store = 1'b1;
        end

        n_dvalid = do_store;
        n_dbyte  = do_store ? store_byte : '0;
        n_dindex = do_store ? len_ext[11:0] : '0;
        if (do_store) begin
            n_fcs = fcs16_update(r_fcs, store_byte);
            n_len = r_len + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_len       <= '0;
            r_hunt      <= 1'b1;
            r_esc       <= 1'b0;
            r_fcs       <= FCS_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (o_pop) begin
                r_len       <= n_len;
                r_hunt      <= n_hunt;
                r_esc       <= n_esc;
                r_fcs       <= n_fcs;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_info   <= n_info;
            r_dvalid <= n_dvalid;
            r_dbyte  <= n_dbyte;
            r_dindex <= n_dindex;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_payload_len = r_info;
    assign o_data_valid  = r_dvalid;
    assign o_data_byte   = r_dbyte;
    assign o_data_index  = r_dindex;

    a_empty_frame_fcs_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) |-> (r_fcs == FCS_INIT))
        else $error("empty frame with non-initial FCS");

    a_hunt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunt |-> (r_len == '0))
        else $error("hunting with bytes in frame");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_len) <= CMP_W'(MAX_FRAME_BYTES))
        else $error("frame length above maximum");

    a_data_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dvalid) |-> (r_status == ST_NONE))
        else $error("stored byte reported with frame end status");

endmodule
